// ===== rtl/spq_pkg.sv =====
// shared types and constants for the sorted priority queue
`timescale 1ns / 1ps

package spq_pkg;

   localparam int DEPTH = 16;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int VAL_W = 32;
   localparam int OCC_W = 5;

   typedef enum logic {
      MODE_PUSH = 1'b0,
      MODE_POP  = 1'b1
   } spq_mode_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } spq_status_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] value;
      logic signed [VAL_W-1:0] prio;
   } spq_entry_type;

   // broadcast to every cell, already qualified by full / empty
   typedef struct packed {
      logic push;
      logic pop;
   } spq_op_type;

endpackage

// ===== rtl/spq_if.sv =====
// request and response channel interfaces of the sorted priority queue
`timescale 1ns / 1ps

interface spq_req_if import spq_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    mode;
   logic signed [VAL_W-1:0] item_value;
   logic signed [VAL_W-1:0] item_priority;

   modport source (output valid, output mode, output item_value, output item_priority,
                   input ready);
   modport sink   (input valid, input mode, input item_value, input item_priority,
                   output ready);
endinterface

interface spq_rsp_if import spq_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [1:0]              status;
   logic signed [VAL_W-1:0] front_value;
   logic signed [VAL_W-1:0] front_priority;
   logic [OCC_W-1:0]        occupancy;

   modport source (output valid, output status, output front_value, output front_priority,
                   output occupancy, input ready);
   modport sink   (input valid, input status, input front_value, input front_priority,
                   input occupancy, output ready);
endinterface

// ===== rtl/spq_cell.sv =====
// one queue slot: holds an entry and shifts toward head or tail
`timescale 1ns / 1ps

module spq_cell import spq_pkg::*; (
   input  logic          clock,
   input  spq_op_type    op,
   input  spq_entry_type new_entry,
   input  spq_entry_type left_entry,
   input  logic          left_ge,
   input  spq_entry_type right_entry,
   input  logic          occupied,
   output spq_entry_type entry,
   output logic          ge
);

   spq_entry_type entry_ff;
   spq_entry_type entry_in;

   // held entry stays ahead of the new one when its priority is not lower
   assign ge = occupied && !(entry_ff.prio < new_entry.prio);

   always_comb begin
      entry_in = entry_ff;
      priority if (op.push) begin
         if (!ge) begin
            entry_in = left_ge ? new_entry : left_entry;
         end
      end else if (op.pop) begin
         entry_in = right_entry;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ===== rtl/spq_chain.sv =====
// row of queue cells, head at index zero
`timescale 1ns / 1ps

module spq_chain import spq_pkg::*; (
   input  logic             clock,
   input  spq_op_type       op,
   input  spq_entry_type    new_entry,
   input  logic [CNT_W-1:0] count,
   output spq_entry_type    front
);

   spq_entry_type cell_entry [DEPTH];
   logic          cell_ge    [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      spq_entry_type left_entry;
      spq_entry_type right_entry;
      logic          left_ge;

      if (i == 0) begin : g_head
         assign left_entry = new_entry;
         assign left_ge    = 1'b1;
      end else begin : g_body
         assign left_entry = cell_entry[i-1];
         assign left_ge    = cell_ge[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_entry = cell_entry[i];
      end else begin : g_inner
         assign right_entry = cell_entry[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .op          (op),
         .new_entry   (new_entry),
         .left_entry  (left_entry),
         .left_ge     (left_ge),
         .right_entry (right_entry),
         .occupied    (CNT_W'(i) < count),
         .entry       (cell_entry[i]),
         .ge          (cell_ge[i])
      );
   end

   assign front = cell_entry[0];

endmodule

// ===== rtl/sorted_priority_queue_top.sv =====
// Sorted priority queue, highest priority first, equal priorities in arrival order.
// Request channel req_chan carries mode (push or pop), item_value and item_priority;
// response channel rsp_chan returns status, front_value, front_priority and the
// occupancy after the operation. Every request beat gives exactly one response beat.
// The queue is a row of DEPTH cells; each cell compares its own priority with the
// incoming one in parallel and either keeps, takes the new entry or takes its
// neighbor, so a push or pop updates the whole row of cells together.
// The response is registered: valid on the cycle after the request is accepted.
// Throughput: one request per cycle when not stalled (single response register).
// A push on a full queue returns status full, a pop on an empty queue returns
// status empty; both leave the queue untouched and report zero value and priority.
// If the receiver stalls, the response holds and req_chan.ready drops until the
// response is taken; ready is high again in the same cycle the response leaves.
// Reset (synchronous, active high) empties the queue and drops the response valid;
// entry storage is not cleared since only held entries are ever read.
`timescale 1ns / 1ps

module sorted_priority_queue_top import spq_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   spq_req_if.sink  req_chan,
   spq_rsp_if.source rsp_chan
);

   logic             accept;
   logic             is_pop;
   logic             full;
   logic             empty;
   spq_op_type       op;
   spq_entry_type    new_entry;
   spq_entry_type    front;

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             rsp_valid_ff;
   spq_status_type   status_ff;
   spq_status_type   status_in;
   spq_entry_type    rsp_entry_ff;
   spq_entry_type    rsp_entry_in;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign is_pop         = (req_chan.mode == MODE_POP);
   assign full           = (count_ff == CNT_W'(DEPTH));
   assign empty          = (count_ff == '0);

   assign op.push = accept && !is_pop && !full;
   assign op.pop  = accept && is_pop && !empty;

   assign new_entry.value = req_chan.item_value;
   assign new_entry.prio  = req_chan.item_priority;

   spq_chain u_chain (
      .clock     (clock),
      .op        (op),
      .new_entry (new_entry),
      .count     (count_ff),
      .front     (front)
   );

   always_comb begin
      count_in     = count_ff;
      status_in    = ST_DONE;
      rsp_entry_in = '0;
      priority if (op.push) begin
         count_in = count_ff + CNT_W'(1);
      end else if (op.pop) begin
         count_in     = count_ff - CNT_W'(1);
         rsp_entry_in = front;
      end else if (is_pop) begin
         status_in = ST_EMPTY;
      end else begin
         status_in = ST_FULL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response payload, loaded with each accepted beat
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff    <= status_in;
         rsp_entry_ff <= rsp_entry_in;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status         = status_ff;
   assign rsp_chan.front_value    = rsp_entry_ff.value;
   assign rsp_chan.front_priority = rsp_entry_ff.prio;
   assign rsp_chan.occupancy      = OCC_W'(count_ff);

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted beat without response");

   a_refused_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (accept && !op.push && !op.pop) |=> (count_ff == $past(count_ff)))
      else $error("refused operation changed the count");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      op.push |=> (count_ff == $past(count_ff) + CNT_W'(1)) && (status_ff == ST_DONE))
      else $error("push did not grow the queue");

   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      op.pop |=> (count_ff == $past(count_ff) - CNT_W'(1)) && (status_ff == ST_DONE))
      else $error("pop did not shrink the queue");
`endif

endmodule

// ===== tb/sorted_priority_queue_top_test.sv =====
// self-checking testbench for the sorted priority queue with random handshake stalls
`timescale 1ns / 1ps

module sorted_priority_queue_top_test import spq_pkg::*; ();

   localparam int CYCLE_LIMIT = 200000;

   typedef struct packed {
      logic [1:0]              status;
      logic signed [VAL_W-1:0] front_value;
      logic signed [VAL_W-1:0] front_priority;
      logic [OCC_W-1:0]        occupancy;
   } queue_result_type;

   logic clock = 1'b0;
   logic reset;

   spq_req_if req_chan ();
   spq_rsp_if rsp_chan ();

   sorted_priority_queue_top i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #10 clock = ~clock;

   // predictor state: held entries, front first
   logic signed [VAL_W-1:0] held_value [DEPTH];
   logic signed [VAL_W-1:0] held_prio  [DEPTH];
   int                      held_count = 0;

   queue_result_type pending_results [$];
   int               fail_count  = 0;
   int               cycle_count = 0;
   int               stall_left  = 0;
   bit               fast_lane   = 1'b0;

   function automatic queue_result_type model_queue_op(input spq_mode_type op,
                                                       input logic signed [VAL_W-1:0] value,
                                                       input logic signed [VAL_W-1:0] prio);
      queue_result_type r;
      int               slot;
      r = '0;
      r.status = ST_DONE;
      if (op == MODE_PUSH) begin
         if (held_count >= DEPTH) begin
            r.status = ST_FULL;
         end else begin
            // insert behind every entry of greater or equal priority
            slot = 0;
            while (slot < held_count && held_prio[slot] >= prio) slot++;
            for (int i = held_count; i > slot; i--) begin
               held_value[i] = held_value[i-1];
               held_prio[i]  = held_prio[i-1];
            end
            held_value[slot] = value;
            held_prio[slot]  = prio;
            held_count++;
         end
      end else begin
         if (held_count == 0) begin
            r.status = ST_EMPTY;
         end else begin
            r.front_value    = held_value[0];
            r.front_priority = held_prio[0];
            for (int i = 1; i < held_count; i++) begin
               held_value[i-1] = held_value[i];
               held_prio[i-1]  = held_prio[i];
            end
            held_count--;
         end
      end
      r.occupancy = OCC_W'(held_count);
      return r;
   endfunction

   task automatic report_failure(input string msg);
      fail_count++;
      if (fail_count <= 10) $display("%0t: %s", $realtime, msg);
   endtask

   // called at a rising edge; returns at the edge where the beat is accepted
   task automatic send_beat(input spq_mode_type op,
                            input logic signed [VAL_W-1:0] value,
                            input logic signed [VAL_W-1:0] prio);
      int gap;
      gap = fast_lane ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.mode          <= op;
      req_chan.item_value    <= value;
      req_chan.item_priority <= prio;
      do @(posedge clock); while (!req_chan.ready);
      pending_results.push_back(model_queue_op(op, value, prio));
   endtask

   // response side: stall per beat, compare each accepted beat with the oldest prediction
   always @(posedge clock) begin
      queue_result_type got, want;
      if (reset) begin
         stall_left      = 0;
         rsp_chan.ready <= 1'b1;
      end else if (rsp_chan.valid && rsp_chan.ready) begin
         got = {rsp_chan.status, rsp_chan.front_value, rsp_chan.front_priority,
                rsp_chan.occupancy};
         if (pending_results.size() == 0) begin
            report_failure($sformatf("response beat with nothing expected: status %0d",
                                     got.status));
         end else begin
            want = pending_results.pop_front();
            if (got !== want)
               report_failure($sformatf({"mismatch: expected status %0d value %0d prio %0d ",
                  "occupancy %0d, got status %0d value %0d prio %0d occupancy %0d"},
                  want.status, want.front_value, want.front_priority, want.occupancy,
                  got.status, got.front_value, got.front_priority, got.occupancy));
         end
         stall_left     = fast_lane ? 0 : $urandom_range(0, 4);
         rsp_chan.ready <= (stall_left == 0);
      end else if (rsp_chan.valid && stall_left > 0) begin
         stall_left     = stall_left - 1;
         rsp_chan.ready <= (stall_left == 0);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("sorted_priority_queue_top_test failed");
         $finish;
      end
   end

   task automatic test_pop_empty();
      send_beat(MODE_POP, 32'sh1234_5678, 32'sh7fff_ffff);
   endtask

   // fill with extremes and ties, then one refused push
   task automatic test_fill_to_full();
      logic signed [VAL_W-1:0] prio_list [DEPTH] = '{
         32'sh7fff_ffff, 32'sh8000_0000, 32'sh0000_0000, 32'shffff_ffff,
         32'sh0000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh0000_0001,
         32'sh0000_0005, 32'sh0000_0005, 32'shffff_fffb, 32'sh0000_0000,
         32'sh4000_0000, 32'shc000_0000, 32'sh7fff_fffe, 32'sh8000_0001};
      logic signed [VAL_W-1:0] value_list [DEPTH] = '{
         32'sh7fff_ffff, 32'sh8000_0000, 32'sh0000_0000, 32'shffff_ffff,
         32'sh5555_5555, 32'shaaaa_aaaa, 32'sh0000_0001, 32'sh8000_0001,
         32'sh0f0f_0f0f, 32'shf0f0_f0f0, 32'sh1234_5678, 32'shedcb_a987,
         32'sh0000_ffff, 32'shffff_0000, 32'sh7fff_0000, 32'sh0000_8000};
      for (int i = 0; i < DEPTH; i++) send_beat(MODE_PUSH, value_list[i], prio_list[i]);
      send_beat(MODE_PUSH, 32'sh6666_6666, 32'sh7fff_ffff);
   endtask

   task automatic test_pop_order();
      for (int i = 0; i < 4; i++) send_beat(MODE_POP, $urandom, $urandom);
   endtask

   // bursts leaning toward push or pop so the queue swings between full and empty
   task automatic test_random_traffic(input int count);
      int                      push_pct;
      logic signed [VAL_W-1:0] prio;
      for (int n = 0; n < count; n++) begin
         if (n % 40 == 0) begin
            case ($urandom_range(0, 2))
               0: begin
                  push_pct = 25;
               end
               1: begin
                  push_pct = 50;
               end
               default: begin
                  push_pct = 80;
               end
            endcase
            fast_lane = ($urandom_range(0, 4) == 0);
         end
         case ($urandom_range(0, 3))
            0: begin
               prio = $urandom;
            end
            1: begin
               prio = $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
            end
            default: begin
               prio = int'($urandom_range(0, 8)) - 4;
            end
         endcase
         if ($urandom_range(1, 100) <= push_pct) send_beat(MODE_PUSH, $urandom, prio);
         else send_beat(MODE_POP, $urandom, $urandom);
      end
      fast_lane = 1'b0;
   endtask

   task automatic test_back_to_back(input int count);
      fast_lane = 1'b1;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 1)) send_beat(MODE_PUSH, $urandom, int'($urandom_range(0, 3)));
         else send_beat(MODE_POP, $urandom, $urandom);
      end
      fast_lane = 1'b0;
   endtask

   initial begin
      reset                  = 1'b1;
      req_chan.valid         = 1'b0;
      req_chan.mode          = MODE_PUSH;
      req_chan.item_value    = '0;
      req_chan.item_priority = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_pop_empty();
      test_fill_to_full();
      test_pop_order();
      test_random_traffic(780);
      test_back_to_back(150);

      req_chan.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (fail_count == 0) begin
         $display("sorted_priority_queue_top_test passed");
      end else begin
         $display("sorted_priority_queue_top_test failed");
      end
      $finish;
   end

endmodule
